>>> sv/assert_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check that is switched off while reset is held.
`define GSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Concurrent check that also holds during reset.
`define GSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> sv/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Types and constants shared by the grid segment projector modules.
// ----------------------------------------------------------------------------
package gsp_pkg;

    // Configuration register indexes.
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Z    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_X    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_ROT_Y    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_TILT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_X = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFSET_Y = 3'd6;

    localparam logic [23:0] WHITE_RGB = 24'hffffff;

    // Register stages from the accepting edge to the result strobe.
    localparam int LATENCY = 7;

    // Width of a rotated grid coordinate in Q14.
    localparam int ROT_W   = 28;
    // Width of a height product (16 x 16 signed).
    localparam int HPROD_W = 32;
    // Width of a screen coordinate before truncation to the port.
    localparam int COORD_W = 33;

    typedef struct packed {
        logic signed [15:0] sx;
        logic signed [15:0] cx;
        logic signed [15:0] sy;
        logic signed [15:0] cy;
        logic               tilt;
        logic        [7:0]  scale;
        logic signed [15:0] ox;
        logic signed [15:0] oy;
    } t_cfg;

endpackage

>>> sv/gsp_point.sv
// ----------------------------------------------------------------------------
// gsp_point
// Tilt, scale, round and offset pipeline for one segment endpoint.
// ----------------------------------------------------------------------------
module gsp_point (
    input  logic                                  i_clk,
    input  gsp_pkg::t_cfg                         i_cfg,
    input  logic signed [gsp_pkg::ROT_W-1:0]      i_x,
    input  logic signed [gsp_pkg::ROT_W-1:0]      i_y,
    input  logic signed [gsp_pkg::HPROD_W-1:0]    i_hcx,
    input  logic signed [gsp_pkg::HPROD_W-1:0]    i_hsy,
    output logic signed [gsp_pkg::COORD_W-1:0]    o_x,
    output logic signed [gsp_pkg::COORD_W-1:0]    o_y
);

    localparam int MUL_W  = 44;
    localparam int V_W    = 47;
    localparam int P_W    = 56;
    localparam int FRAC   = 28;
    localparam int INT_W  = P_W - FRAC;
    localparam logic signed [P_W-1:0] HALF = 56'sd134217728;

    // Stage A: tilt products.
    logic signed [MUL_W-1:0]            r_xm, r_ym;
    logic signed [gsp_pkg::ROT_W-1:0]   r_x0, r_y0;
    logic signed [gsp_pkg::HPROD_W-1:0] r_hcx, r_hsy;
    // Stage B: Q28 value.
    logic signed [V_W-1:0]              r_vx, r_vy;
    // Stage C: scaled value.
    logic signed [P_W-1:0]              r_px, r_py;
    // Stage D: rounded coordinate plus offset.
    logic signed [gsp_pkg::COORD_W-1:0] r_cx, r_cy;

    logic signed [MUL_W-1:0]            n_xm, n_ym;
    logic signed [V_W-1:0]              n_vx, n_vy;
    logic signed [P_W-1:0]              n_px, n_py, scale_x, sum_x, sum_y;
    logic signed [gsp_pkg::COORD_W-1:0] n_cx, n_cy;

    always_comb begin
        n_xm = MUL_W'(i_x) * MUL_W'(i_cfg.cy);
        n_ym = MUL_W'(i_y) * MUL_W'(i_cfg.sx);

        // With tilt off the Q14 value is lifted to Q28 so one rounder serves both.
        if (i_cfg.tilt) begin
            n_vx = V_W'(r_xm) - (V_W'(r_hsy) <<< 14);
            n_vy = V_W'(r_ym) - (V_W'(r_hcx) <<< 14);
        end else begin
            n_vx = V_W'(r_x0) <<< 14;
            n_vy = V_W'(r_y0) <<< 14;
        end

        scale_x = $signed({{(P_W-8){1'b0}}, i_cfg.scale});
        n_px    = P_W'(r_vx) * scale_x;
        n_py    = P_W'(r_vy) * scale_x;

        // Adding one half and dropping the fraction rounds half upward.
        sum_x = r_px + HALF;
        sum_y = r_py + HALF;
        n_cx  = gsp_pkg::COORD_W'($signed(sum_x[P_W-1:FRAC]))
              + gsp_pkg::COORD_W'(i_cfg.ox);
        n_cy  = gsp_pkg::COORD_W'($signed(sum_y[P_W-1:FRAC]))
              + gsp_pkg::COORD_W'(i_cfg.oy);
    end

    always_ff @(posedge i_clk) begin
        r_xm  <= n_xm;
        r_ym  <= n_ym;
        r_x0  <= i_x;
        r_y0  <= i_y;
        r_hcx <= i_hcx;
        r_hsy <= i_hsy;
        r_vx  <= n_vx;
        r_vy  <= n_vy;
        r_px  <= n_px;
        r_py  <= n_py;
        r_cx  <= n_cx;
        r_cy  <= n_cy;
    end

    assign o_x = r_cx;
    assign o_y = r_cy;

    // INT_W documents the integer part kept by the rounder.
    if (INT_W != gsp_pkg::ROT_W) begin : g_bad_width
        $error("gsp_point: integer width mismatch");
    end

endmodule

>>> sv/grid_segment_projector.sv
// ----------------------------------------------------------------------------
// grid_segment_projector
// Projects the vertical wireframe segment from one height-map point to the
// point one row below into screen coordinates.
// ----------------------------------------------------------------------------
// Usage:
// An item is taken at a rising edge with i_start high and o_busy low. The
// block never stalls, so o_busy stays low and one item can enter per clock.
// Each item gives exactly one result, shown on the o_ ports for one cycle
// with o_done high. Throughput is one item per cycle; each item passes
// the seven register stages: products, rotation sums, tilt products, tilt
// difference, scaling, rounding with offset, and the visibility compare.
// The receiver cannot hold results off; every strobed result is final.
// Configuration registers are written through i_cfg_valid / o_cfg_ready with
// an index and 32 data bits; o_cfg_ready is always high and an index past
// the last register is ignored. Writes are meant for an idle pipeline.
// A synchronous active-low reset empties the pipeline and restores the
// register reset values (unit rotations, tilt off, scale 20, zero offsets).
// ----------------------------------------------------------------------------
module grid_segment_projector #(
    parameter int SCREEN_WIDTH  = 2048,
    parameter int SCREEN_HEIGHT = 1024
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    output logic                            o_busy,
    input  logic [9:0]                      i_col,
    input  logic [9:0]                      i_row,
    input  logic signed [15:0]              i_z_here,
    input  logic signed [15:0]              i_z_below,
    input  logic [23:0]                     i_color,
    input  logic                            i_past_edge,
    input  logic                            i_last_row,
    output logic                            o_done,
    output logic signed [31:0]              o_x_start,
    output logic signed [31:0]              o_y_start,
    output logic signed [31:0]              o_x_end,
    output logic signed [31:0]              o_y_end,
    output logic [23:0]                     o_seg_color,
    output logic                            o_visible,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [gsp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [31:0]                     i_cfg_data
);

    localparam int P1_W = 27;
    localparam int LAT  = gsp_pkg::LATENCY;
    localparam logic signed [gsp_pkg::COORD_W-1:0] SCR_W = gsp_pkg::COORD_W'(SCREEN_WIDTH);
    localparam logic signed [gsp_pkg::COORD_W-1:0] SCR_H = gsp_pkg::COORD_W'(SCREEN_HEIGHT);

    // Configuration registers.
    logic [31:0]        r_rot_z, r_rot_x, r_rot_y;
    logic               r_tilt;
    logic [7:0]         r_scale;
    logic signed [15:0] r_ox, r_oy;
    gsp_pkg::t_cfg      cfg;

    // Pipeline control and color.
    logic [LAT-1:0]     r_vld, n_vld;
    logic [23:0]        r_color [LAT];
    logic               in_acc;

    // Stage 1 products.
    logic signed [P1_W-1:0]             r_ccz, r_rsz, r_csz, r_rcz;
    logic signed [P1_W-1:0]             n_ccz, n_rsz, n_csz, n_rcz, col_x, row_x, sz_x, cz_x;
    logic signed [gsp_pkg::HPROD_W-1:0] r_h1cx, r_h1sy, r_h2cx, r_h2sy;
    logic signed [gsp_pkg::HPROD_W-1:0] h1_x, h2_x, cx_x, sy_x;
    logic signed [15:0]                 h1, h2, sz, cz;
    logic [23:0]                        seg_color;

    // Stage 2 rotated coordinates and delayed height products.
    logic signed [gsp_pkg::ROT_W-1:0]   r_x1, r_y1, r_x2, r_y2;
    logic signed [gsp_pkg::ROT_W-1:0]   n_x1, n_y1;
    logic signed [gsp_pkg::HPROD_W-1:0] r2_h1cx, r2_h1sy, r2_h2cx, r2_h2sy;

    // Endpoint pipeline outputs.
    logic signed [gsp_pkg::COORD_W-1:0] xs, ys, xe, ye;
    logic                               vis_s, vis_e;

    // Output registers.
    logic signed [31:0] r_xs, r_ys, r_xe, r_ye;
    logic               r_vis;

    assign o_busy      = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign in_acc      = i_start && !o_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_z <= 32'd16384;
            r_rot_x <= 32'd16384;
            r_rot_y <= 32'd16384;
            r_tilt  <= 1'b0;
            r_scale <= 8'd20;
            r_ox    <= 16'sd0;
            r_oy    <= 16'sd0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                gsp_pkg::CFG_ROT_Z:    r_rot_z <= i_cfg_data;
                gsp_pkg::CFG_ROT_X:    r_rot_x <= i_cfg_data;
                gsp_pkg::CFG_ROT_Y:    r_rot_y <= i_cfg_data;
                gsp_pkg::CFG_TILT:     r_tilt  <= i_cfg_data[0];
                gsp_pkg::CFG_SCALE:    r_scale <= i_cfg_data[7:0];
                gsp_pkg::CFG_OFFSET_X: r_ox    <= $signed(i_cfg_data[15:0]);
                gsp_pkg::CFG_OFFSET_Y: r_oy    <= $signed(i_cfg_data[15:0]);
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.sx    = $signed(r_rot_x[31:16]);
        cfg.cx    = $signed(r_rot_x[15:0]);
        cfg.sy    = $signed(r_rot_y[31:16]);
        cfg.cy    = $signed(r_rot_y[15:0]);
        cfg.tilt  = r_tilt;
        cfg.scale = r_scale;
        cfg.ox    = r_ox;
        cfg.oy    = r_oy;
    end

    // Stage 1: rotation and height products.
    always_comb begin
        sz    = $signed(r_rot_z[31:16]);
        cz    = $signed(r_rot_z[15:0]);
        h1    = i_past_edge ? 16'sd0 : i_z_here;
        h2    = (i_past_edge || i_last_row) ? 16'sd0 : i_z_below;
        seg_color = (i_past_edge || i_color == 24'd0) ? gsp_pkg::WHITE_RGB : i_color;

        col_x = $signed({{(P1_W-10){1'b0}}, i_col});
        row_x = $signed({{(P1_W-10){1'b0}}, i_row});
        sz_x  = P1_W'(sz);
        cz_x  = P1_W'(cz);
        n_ccz = col_x * cz_x;
        n_rsz = row_x * sz_x;
        n_csz = col_x * sz_x;
        n_rcz = row_x * cz_x;

        h1_x  = gsp_pkg::HPROD_W'(h1);
        h2_x  = gsp_pkg::HPROD_W'(h2);
        cx_x  = gsp_pkg::HPROD_W'(cfg.cx);
        sy_x  = gsp_pkg::HPROD_W'(cfg.sy);
    end

    // Stage 2: the lower row adds one more sine or cosine step.
    always_comb begin
        n_x1 = gsp_pkg::ROT_W'(r_ccz) - gsp_pkg::ROT_W'(r_rsz);
        n_y1 = gsp_pkg::ROT_W'(r_csz) + gsp_pkg::ROT_W'(r_rcz);
    end

    always_comb begin
        n_vld = {r_vld[LAT-2:0], in_acc};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ccz   <= n_ccz;
        r_rsz   <= n_rsz;
        r_csz   <= n_csz;
        r_rcz   <= n_rcz;
        r_h1cx  <= h1_x * cx_x;
        r_h1sy  <= h1_x * sy_x;
        r_h2cx  <= h2_x * cx_x;
        r_h2sy  <= h2_x * sy_x;

        r_x1    <= n_x1;
        r_y1    <= n_y1;
        r_x2    <= n_x1 - gsp_pkg::ROT_W'(sz);
        r_y2    <= n_y1 + gsp_pkg::ROT_W'(cz);
        r2_h1cx <= r_h1cx;
        r2_h1sy <= r_h1sy;
        r2_h2cx <= r_h2cx;
        r2_h2sy <= r_h2sy;

        r_color[0] <= seg_color;
        for (int i = 1; i < LAT; i++) begin
            r_color[i] <= r_color[i-1];
        end

        r_xs  <= xs[31:0];
        r_ys  <= ys[31:0];
        r_xe  <= xe[31:0];
        r_ye  <= ye[31:0];
        r_vis <= vis_s || vis_e;
    end

    gsp_point u_start (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_x   (r_x1),
        .i_y   (r_y1),
        .i_hcx (r2_h1cx),
        .i_hsy (r2_h1sy),
        .o_x   (xs),
        .o_y   (ys)
    );

    gsp_point u_end (
        .i_clk (i_clk),
        .i_cfg (cfg),
        .i_x   (r_x2),
        .i_y   (r_y2),
        .i_hcx (r2_h2cx),
        .i_hsy (r2_h2sy),
        .o_x   (xe),
        .o_y   (ye)
    );

    // Strictly inside the screen on the full-width rounded coordinates.
    assign vis_s = (xs > 0) && (ys > 0) && (xs < SCR_W) && (ys < SCR_H);
    assign vis_e = (xe > 0) && (ye > 0) && (xe < SCR_W) && (ye < SCR_H);

    assign o_done      = r_vld[LAT-1];
    assign o_x_start   = r_xs;
    assign o_y_start   = r_ys;
    assign o_x_end     = r_xe;
    assign o_y_end     = r_ye;
    assign o_seg_color = r_color[LAT-1];
    assign o_visible   = r_vis;

endmodule

>>> sv/gsp_checker.sv
// ----------------------------------------------------------------------------
// gsp_checker
// Port-level checks of the grid segment projector, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gsp_checker #(
    parameter int SCREEN_WIDTH  = 2048,
    parameter int SCREEN_HEIGHT = 1024
) (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_start,
    input logic               o_busy,
    input logic               i_past_edge,
    input logic               o_done,
    input logic signed [31:0] o_x_start,
    input logic signed [31:0] o_y_start,
    input logic signed [31:0] o_x_end,
    input logic signed [31:0] o_y_end,
    input logic [23:0]        o_seg_color,
    input logic               o_visible
);

    localparam logic signed [31:0] SCR_W = 32'(SCREEN_WIDTH);
    localparam logic signed [31:0] SCR_H = 32'(SCREEN_HEIGHT);

    logic acc, ins_s, ins_e;

    assign acc   = i_start && !o_busy;
    assign ins_s = (o_x_start > 0) && (o_y_start > 0) && (o_x_start < SCR_W)
                && (o_y_start < SCR_H);
    assign ins_e = (o_x_end > 0) && (o_y_end > 0) && (o_x_end < SCR_W)
                && (o_y_end < SCR_H);

    // Every item taken comes out after the fixed latency.
    `GSP_ASSERT(a_item_out, i_clk, i_rst_n, acc |-> ##(gsp_pkg::LATENCY) o_done, "item lost")
    // No result without an item taken the fixed latency earlier.
    `GSP_ASSERT(a_no_extra, i_clk, i_rst_n, o_done |-> $past(acc, gsp_pkg::LATENCY), "extra result")
    // The visible flag agrees with the coordinates shown.
    `GSP_ASSERT(a_visible, i_clk, i_rst_n, o_done |-> (o_visible == (ins_s || ins_e)), "bad visible")
    // A point past the last column always draws in white.
    `GSP_ASSERT(a_edge_white, i_clk, i_rst_n, (o_done && $past(i_past_edge, gsp_pkg::LATENCY)) |-> (o_seg_color == gsp_pkg::WHITE_RGB), "edge not white")
    // Reset empties the pipeline.
    `GSP_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> !o_done, "result after reset")

endmodule

bind grid_segment_projector gsp_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_gsp_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_start     (i_start),
    .o_busy      (o_busy),
    .i_past_edge (i_past_edge),
    .o_done      (o_done),
    .o_x_start   (o_x_start),
    .o_y_start   (o_y_start),
    .o_x_end     (o_x_end),
    .o_y_end     (o_y_end),
    .o_seg_color (o_seg_color),
    .o_visible   (o_visible)
);

>>> dv/grid_segment_projector_tb.sv
// ----------------------------------------------------------------------------
// grid_segment_projector_tb
// Self-checking bench for the grid segment projector. A short directed list
// covers the reset settings, field extremes, the edge and last-row cases,
// zero scale and an unused register index. Randomized phases then reprogram
// every register and stream grid points with random gaps. Each result is
// compared field by field to a typed expectation or an in-bench projection.
// ----------------------------------------------------------------------------
module grid_segment_projector_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SCREEN_W = 2048;
    localparam int SCREEN_H = 1024;
    localparam int WATCHDOG_LIMIT = 300;
    localparam int PHASES = 9;
    localparam int POINTS_PER_PHASE = 50;
    localparam int MAX_PRINTED = 40;
    localparam logic [gsp_pkg::CFG_IDX_W-1:0] CFG_NONE = 3'd7;

    typedef struct packed {
        logic [9:0]         col;
        logic [9:0]         row;
        logic signed [15:0] z_here;
        logic signed [15:0] z_below;
        logic [23:0]        color;
        logic               past_edge;
        logic               last_row;
    } t_point;

    typedef struct packed {
        logic signed [31:0] x_start;
        logic signed [31:0] y_start;
        logic signed [31:0] x_end;
        logic signed [31:0] y_end;
        logic [23:0]        seg_color;
        logic               visible;
    } t_segment;

    typedef struct {
        bit                            is_cfg;
        logic [gsp_pkg::CFG_IDX_W-1:0] idx;
        logic [31:0]                   data;
        t_point                        pnt;
        bit                            known;
        t_segment                      want;
    } t_step;

    logic                          i_clk = 1'b0;
    logic                          i_rst_n = 1'b0;
    logic                          i_start = 1'b0;
    logic                          o_busy;
    logic [9:0]                    i_col = '0;
    logic [9:0]                    i_row = '0;
    logic signed [15:0]            i_z_here = '0;
    logic signed [15:0]            i_z_below = '0;
    logic [23:0]                   i_color = '0;
    logic                          i_past_edge = 1'b0;
    logic                          i_last_row = 1'b0;
    logic                          o_done;
    logic signed [31:0]            o_x_start;
    logic signed [31:0]            o_y_start;
    logic signed [31:0]            o_x_end;
    logic signed [31:0]            o_y_end;
    logic [23:0]                   o_seg_color;
    logic                          o_visible;
    logic                          i_cfg_valid = 1'b0;
    logic                          o_cfg_ready;
    logic [gsp_pkg::CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [31:0]                   i_cfg_data = '0;

    // Typed expectation that travels with the item on the input ports.
    logic     typed_known = 1'b0;
    t_segment typed_segment = '0;

    // Register copies used by the projection.
    logic [31:0]        rot_z_q;
    logic [31:0]        rot_x_q;
    logic [31:0]        rot_y_q;
    logic               tilt_q;
    logic [7:0]         scale_q;
    logic signed [15:0] off_x_q;
    logic signed [15:0] off_y_q;

    t_segment pending_segments[$];
    t_step    directed_steps[$];
    t_segment got_segment;
    t_segment want_segment;
    int       points_sent = 0;
    int       segments_seen = 0;
    int       mismatches = 0;
    int       quiet_cycles = 0;
    bit       start_held = 1'b0;
    bit       cfg_held = 1'b0;
    bit       burst = 1'b0;

    grid_segment_projector #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_col       (i_col),
        .i_row       (i_row),
        .i_z_here    (i_z_here),
        .i_z_below   (i_z_below),
        .i_color     (i_color),
        .i_past_edge (i_past_edge),
        .i_last_row  (i_last_row),
        .o_done      (o_done),
        .o_x_start   (o_x_start),
        .o_y_start   (o_y_start),
        .o_x_end     (o_x_end),
        .o_y_end     (o_y_end),
        .o_seg_color (o_seg_color),
        .o_visible   (o_visible),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // floor((v + half) / 2^q), so halves round toward plus infinity.
    function automatic longint round_q(longint v, int q);
        return (v + (longint'(1) <<< (q - 1))) >>> q;
    endfunction

    function automatic bit on_screen(longint x, longint y);
        return x > 0 && y > 0 && x < SCREEN_W && y < SCREEN_H;
    endfunction

    function automatic t_segment project(t_point p);
        longint col, row, h1, h2, sz, cz, sx, cx, sy, cy;
        longint x1, x2, y1, y2, sc, ox, oy, xs, ys, xe, ye;
        int q;
        t_segment s;
        col = longint'(p.col);
        row = longint'(p.row);
        h1 = p.past_edge ? 0 : longint'(p.z_here);
        h2 = (p.past_edge || p.last_row) ? 0 : longint'(p.z_below);
        sz = longint'($signed(rot_z_q[31:16]));
        cz = longint'($signed(rot_z_q[15:0]));
        x1 = col * cz - row * sz;
        x2 = col * cz - (row + 1) * sz;
        y1 = col * sz + row * cz;
        y2 = col * sz + (row + 1) * cz;
        q = 14;
        if (tilt_q) begin
            sx = longint'($signed(rot_x_q[31:16]));
            cx = longint'($signed(rot_x_q[15:0]));
            sy = longint'($signed(rot_y_q[31:16]));
            cy = longint'($signed(rot_y_q[15:0]));
            y1 = y1 * sx - h1 * cx * 16384;
            y2 = y2 * sx - h2 * cx * 16384;
            x1 = x1 * cy - h1 * sy * 16384;
            x2 = x2 * cy - h2 * sy * 16384;
            q = 28;
        end
        sc = longint'(scale_q);
        ox = longint'(off_x_q);
        oy = longint'(off_y_q);
        xs = round_q(x1 * sc, q) + ox;
        ys = round_q(y1 * sc, q) + oy;
        xe = round_q(x2 * sc, q) + ox;
        ye = round_q(y2 * sc, q) + oy;
        s.x_start = xs[31:0];
        s.y_start = ys[31:0];
        s.x_end = xe[31:0];
        s.y_end = ye[31:0];
        s.seg_color = (p.past_edge || p.color == 24'd0) ? gsp_pkg::WHITE_RGB : p.color;
        s.visible = on_screen(xs, ys) || on_screen(xe, ye);
        return s;
    endfunction

    task automatic report(string what, logic [31:0] got, logic [31:0] want);
        if (mismatches < MAX_PRINTED)
            $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    task automatic compare_segment(t_segment got, t_segment want);
        if (got.x_start !== want.x_start) report("x_start", got.x_start, want.x_start);
        if (got.y_start !== want.y_start) report("y_start", got.y_start, want.y_start);
        if (got.x_end !== want.x_end) report("x_end", got.x_end, want.x_end);
        if (got.y_end !== want.y_end) report("y_end", got.y_end, want.y_end);
        if (got.seg_color !== want.seg_color)
            report("seg_color", 32'(got.seg_color), 32'(want.seg_color));
        if (got.visible !== want.visible)
            report("visible", 32'(got.visible), 32'(want.visible));
    endtask

    // Register writes, item acceptance and result checking, all sampled at the edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rot_z_q <= 32'd16384;
            rot_x_q <= 32'd16384;
            rot_y_q <= 32'd16384;
            tilt_q <= 1'b0;
            scale_q <= 8'd20;
            off_x_q <= '0;
            off_y_q <= '0;
        end else begin
            if (o_done === 1'b1) begin
                got_segment = {o_x_start, o_y_start, o_x_end, o_y_end, o_seg_color, o_visible};
                if (pending_segments.size() == 0) begin
                    report("result with nothing pending", got_segment.x_start, 0);
                end else begin
                    want_segment = pending_segments.pop_front();
                    compare_segment(got_segment, want_segment);
                end
                segments_seen++;
            end
            if (i_cfg_valid && o_cfg_ready === 1'b1) begin
                case (i_cfg_index)
                    gsp_pkg::CFG_ROT_Z:    rot_z_q <= i_cfg_data;
                    gsp_pkg::CFG_ROT_X:    rot_x_q <= i_cfg_data;
                    gsp_pkg::CFG_ROT_Y:    rot_y_q <= i_cfg_data;
                    gsp_pkg::CFG_TILT:     tilt_q <= i_cfg_data[0];
                    gsp_pkg::CFG_SCALE:    scale_q <= i_cfg_data[7:0];
                    gsp_pkg::CFG_OFFSET_X: off_x_q <= i_cfg_data[15:0];
                    gsp_pkg::CFG_OFFSET_Y: off_y_q <= i_cfg_data[15:0];
                    default: ;
                endcase
            end
            if (i_start && o_busy === 1'b0)
                pending_segments.push_back(typed_known ? typed_segment : project({i_col, i_row,
                    i_z_here, i_z_below, i_color, i_past_edge, i_last_row}));
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && o_busy === 1'b0) || o_done === 1'b1
                || (i_cfg_valid && o_cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_point(t_point p, bit known, t_segment want);
        int gap;
        if (cfg_held) begin
            i_cfg_valid <= 1'b0;
            cfg_held = 1'b0;
        end
        i_start <= 1'b1;
        {i_col, i_row, i_z_here, i_z_below, i_color, i_past_edge, i_last_row} <= p;
        typed_known <= known;
        typed_segment <= want;
        start_held = 1'b1;
        do @(posedge i_clk); while (o_busy !== 1'b0);
        points_sent++;
        // Alternate between back-to-back bursts and randomly spaced items.
        if ($urandom_range(0, 15) == 0) burst = !burst;
        gap = burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            i_start <= 1'b0;
            start_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Registers may only change once every item in flight has come out.
    task automatic wait_idle();
        if (start_held) begin
            i_start <= 1'b0;
            start_held = 1'b0;
        end
        while (segments_seen != points_sent) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [gsp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
        cfg_held = 1'b1;
    endtask

    function automatic t_point pt(int col, int row, int zh, int zb, int color,
                                  bit past, bit last);
        t_point p;
        p.col = 10'(col);
        p.row = 10'(row);
        p.z_here = 16'(zh);
        p.z_below = 16'(zb);
        p.color = 24'(color);
        p.past_edge = past;
        p.last_row = last;
        return p;
    endfunction

    function automatic t_segment sg(int xs, int ys, int xe, int ye, int color, bit vis);
        t_segment s;
        s.x_start = xs;
        s.y_start = ys;
        s.x_end = xe;
        s.y_end = ye;
        s.seg_color = 24'(color);
        s.visible = vis;
        return s;
    endfunction

    function automatic t_step cfg_step(logic [gsp_pkg::CFG_IDX_W-1:0] idx, logic [31:0] data);
        t_step s;
        s = '{default: '0};
        s.is_cfg = 1'b1;
        s.idx = idx;
        s.data = data;
        return s;
    endfunction

    function automatic t_step point_step(t_point p, bit known, t_segment want);
        t_step s;
        s = '{default: '0};
        s.pnt = p;
        s.known = known;
        s.want = want;
        return s;
    endfunction

    function automatic logic [15:0] corner16();
        case ($urandom_range(0, 5))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'h0000;
            3: return 16'h4000;
            4: return 16'hc000;
            default: return 16'hffff;
        endcase
    endfunction

    function automatic logic [31:0] draw_rotation(bit tame);
        real a;
        int s, c;
        if (tame) begin
            a = $urandom_range(0, 359) * 0.0174532925;
            s = $rtoi(16384.0 * $sin(a));
            c = $rtoi(16384.0 * $cos(a));
            return {s[15:0], c[15:0]};
        end
        return $urandom_range(0, 1) ? $urandom() : {corner16(), corner16()};
    endfunction

    function automatic t_point draw_point(bit tame);
        t_point p;
        p.col = tame ? 10'($urandom_range(0, 63)) : 10'($urandom());
        p.row = tame ? 10'($urandom_range(0, 63)) : 10'($urandom());
        p.z_here = tame ? 16'($urandom_range(0, 400) - 200) : 16'($urandom());
        p.z_below = tame ? 16'($urandom_range(0, 400) - 200) : 16'($urandom());
        p.color = ($urandom_range(0, 7) == 0) ? 24'd0 : 24'($urandom());
        p.past_edge = ($urandom_range(0, 7) == 0);
        p.last_row = ($urandom_range(0, 7) == 0);
        return p;
    endfunction

    task automatic program_phase(int phase, bit tame);
        if (phase == 0) begin
            write_reg(gsp_pkg::CFG_ROT_Z, 32'h7fff_7fff);
            write_reg(gsp_pkg::CFG_ROT_X, 32'h7fff_7fff);
            write_reg(gsp_pkg::CFG_ROT_Y, 32'h7fff_7fff);
            write_reg(gsp_pkg::CFG_TILT, 32'h0000_0001);
            write_reg(gsp_pkg::CFG_SCALE, 32'h0000_00ff);
            write_reg(gsp_pkg::CFG_OFFSET_X, 32'h0000_7fff);
            write_reg(gsp_pkg::CFG_OFFSET_Y, 32'h0000_7fff);
        end else if (phase == 1) begin
            write_reg(gsp_pkg::CFG_ROT_Z, 32'h8000_8000);
            write_reg(gsp_pkg::CFG_ROT_X, 32'h8000_8000);
            write_reg(gsp_pkg::CFG_ROT_Y, 32'h8000_8000);
            write_reg(gsp_pkg::CFG_TILT, 32'hffff_fffe);
            write_reg(gsp_pkg::CFG_SCALE, 32'hffff_ff01);
            write_reg(gsp_pkg::CFG_OFFSET_X, 32'hffff_8000);
            write_reg(gsp_pkg::CFG_OFFSET_Y, 32'hffff_8000);
        end else begin
            write_reg(gsp_pkg::CFG_ROT_Z, draw_rotation(tame));
            write_reg(gsp_pkg::CFG_ROT_X, draw_rotation(tame));
            write_reg(gsp_pkg::CFG_ROT_Y, draw_rotation(tame));
            write_reg(gsp_pkg::CFG_TILT, $urandom());
            // Upper data bits are random throughout to exercise width masking.
            write_reg(gsp_pkg::CFG_SCALE, tame ? {24'($urandom()), 8'($urandom_range(1, 24))}
                                               : $urandom());
            write_reg(gsp_pkg::CFG_OFFSET_X, tame ? {16'($urandom()),
                                                     16'($urandom_range(0, 1500))}
                                                  : $urandom());
            write_reg(gsp_pkg::CFG_OFFSET_Y, tame ? {16'($urandom()),
                                                     16'($urandom_range(0, 800))}
                                                  : $urandom());
            if ($urandom_range(0, 2) == 0) write_reg(CFG_NONE, $urandom());
        end
    endtask

    initial begin
        bit tame;
        // Reset settings: unit cosine, no sine, tilt off, scale 20, no offsets,
        // so every coordinate is the grid index times 20.
        directed_steps.push_back(point_step(pt(0, 0, 0, 0, 'h123456, 0, 0), 1,
                                 sg(0, 0, 0, 20, 'h123456, 0)));
        directed_steps.push_back(point_step(pt(1, 1, 5, 7, 0, 0, 0), 1,
                                 sg(20, 20, 20, 40, 'hffffff, 1)));
        directed_steps.push_back(point_step(pt(1023, 1023, 32767, -32768, 'hffffff, 0, 0), 1,
                                 sg(20460, 20460, 20460, 20480, 'hffffff, 0)));
        directed_steps.push_back(point_step(pt(10, 5, -32768, 32767, 'habcdef, 1, 0), 1,
                                 sg(200, 100, 200, 120, 'hffffff, 1)));
        directed_steps.push_back(point_step(pt(50, 49, -1, 300, 'h000001, 0, 1), 1,
                                 sg(1000, 980, 1000, 1000, 'h000001, 1)));
        directed_steps.push_back(point_step(pt(102, 51, 0, 0, 'h800000, 0, 0), 1,
                                 sg(2040, 1020, 2040, 1040, 'h800000, 1)));
        directed_steps.push_back(point_step(pt(103, 51, 0, 0, 'h00ff00, 0, 0), 1,
                                 sg(2060, 1020, 2060, 1040, 'h00ff00, 0)));
        directed_steps.push_back(point_step(pt(0, 5, 0, 0, 'h0000ff, 1, 1), 1,
                                 sg(0, 100, 0, 120, 'hffffff, 0)));
        // Extreme rotations with tilt on; the mask keeps only bit 0 of tilt.
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_ROT_Z, 32'h8000_8000));
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_ROT_X, 32'h7fff_8000));
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_ROT_Y, 32'h8000_7fff));
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_TILT, 32'hffff_ffff));
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_SCALE, 32'h1234_56ff));
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_OFFSET_X, 32'hffff_8000));
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_OFFSET_Y, 32'h0000_7fff));
        directed_steps.push_back(point_step(pt(1023, 1023, 32767, -32768, 'hfedcba, 0, 0),
                                 0, '0));
        directed_steps.push_back(point_step(pt(1023, 0, -32768, 32767, 0, 0, 0), 0, '0));
        directed_steps.push_back(point_step(pt(0, 1023, -32768, -32768, 'h00aa55, 0, 1),
                                 0, '0));
        directed_steps.push_back(point_step(pt(512, 511, 32767, 32767, 'h55aa00, 1, 0),
                                 0, '0));
        directed_steps.push_back(point_step(pt(341, 682, 1234, -4321, 'h0f0f0f, 0, 0),
                                 0, '0));
        // Zero scale collapses every point onto the offsets; index 7 is unused.
        directed_steps.push_back(cfg_step(gsp_pkg::CFG_SCALE, 32'habcd_ef00));
        directed_steps.push_back(cfg_step(CFG_NONE, 32'hffff_ffff));
        directed_steps.push_back(point_step(pt(1023, 1023, 32767, 32767, 'h0000ff, 0, 0),
                                 0, '0));
        directed_steps.push_back(point_step(pt(7, 9, -32768, 100, 0, 0, 1), 0, '0));

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[k]) begin
            if (directed_steps[k].is_cfg) begin
                wait_idle();
                write_reg(directed_steps[k].idx, directed_steps[k].data);
            end else begin
                send_point(directed_steps[k].pnt, directed_steps[k].known,
                           directed_steps[k].want);
            end
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            // Most phases keep values near a real screen so that visibility toggles.
            tame = (phase < 2) || (phase % 3 != 2);
            wait_idle();
            program_phase(phase, tame);
            for (int n = 0; n < POINTS_PER_PHASE; n++)
                send_point(draw_point(tame && $urandom_range(0, 6) != 0), 0, '0);
        end

        wait_idle();
        if (cfg_held) i_cfg_valid <= 1'b0;
        repeat (gsp_pkg::LATENCY + 4) @(posedge i_clk);
        if (pending_segments.size() != 0)
            report("results never arrived", pending_segments.size(), 0);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
